// File: sv/pwfr_pkg.sv
// ---------------------------------------------------------------------------
// pwfr_pkg
// Shared constants, types and the pulse window compare for the pulse width
// frame receiver.
// ---------------------------------------------------------------------------
package pwfr_pkg;

    localparam int MSG_BYTES = 16;
    localparam int BYTE_CNT_W = 6;
    localparam int WIDTH_W = 16;
    localparam int CFG_W = 15;

    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(MSG_BYTES - 1);

    localparam logic [2:0] CAL_PULSES = 3'd3;
    localparam logic [2:0] LEADOUT_PULSES = 3'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] REG_RX_ENABLE = 2'd0;
    localparam logic [1:0] REG_ZERO_WIDTH = 2'd1;
    localparam logic [1:0] REG_ONE_WIDTH = 2'd2;

    typedef struct packed {
        logic timeout;
        logic zero_hit;
        logic one_hit;
        logic trailer_hit;
    } match_t;

    function automatic logic in_window(input logic [WIDTH_W-1:0] w,
                                       input logic [WIDTH_W-1:0] target);
        logic [WIDTH_W-1:0] lo;
        logic [WIDTH_W:0]   hi;
        lo = (target == '0) ? '0 : target - WIDTH_W'(1);
        hi = {1'b0, target} + (WIDTH_W+1)'(1);
        return (w >= lo) && ({1'b0, w} <= hi);
    endfunction

endpackage

// File: sv/pwfr_match.sv
// ---------------------------------------------------------------------------
// pwfr_match
// Window compares of one pulse width against the zero, one and trailer
// targets, and a timeout flag for a zero pulse width.
// ---------------------------------------------------------------------------
module pwfr_match (
    input  logic [pwfr_pkg::WIDTH_W-1:0] pulse_width,
    input  logic [pwfr_pkg::CFG_W-1:0]   zero_width,
    input  logic [pwfr_pkg::CFG_W-1:0]   one_width,
    output pwfr_pkg::match_t             match
);

    logic [pwfr_pkg::WIDTH_W-1:0] zero_t;
    logic [pwfr_pkg::WIDTH_W-1:0] one_t;
    logic [pwfr_pkg::WIDTH_W-1:0] trailer_t;

    assign zero_t    = {1'b0, zero_width};
    assign one_t     = {1'b0, one_width};
    assign trailer_t = zero_t + one_t;

    assign match.timeout     = (pulse_width == '0);
    assign match.zero_hit    = pwfr_pkg::in_window(pulse_width, zero_t);
    assign match.one_hit     = pwfr_pkg::in_window(pulse_width, one_t);
    assign match.trailer_hit = pwfr_pkg::in_window(pulse_width, trailer_t);

endmodule

// File: sv/pwfr_fsm.sv
// ---------------------------------------------------------------------------
// pwfr_fsm
// Frame sequencer and result register: steps through the calibration,
// trailer, data and lead-out phases and holds one result for the output.
// ---------------------------------------------------------------------------
module pwfr_fsm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rx_enable,
    input  logic                                item_valid,
    input  pwfr_pkg::match_t                    match,
    output logic                                item_taken,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_kind,
    output logic [7:0]                          out_byte,
    output logic [pwfr_pkg::BYTE_CNT_W-1:0]     out_index
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ZERO    = 3'd1;
    localparam logic [2:0] PH_ONE     = 3'd2;
    localparam logic [2:0] PH_TRAILER = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;
    localparam logic [2:0] PH_LEADOUT = 3'd5;

    logic [2:0]                      phase_reg, phase_next;
    logic [2:0]                      count_reg, count_next;
    logic [2:0]                      bitpos_reg, bitpos_next;
    logic [pwfr_pkg::BYTE_CNT_W-1:0] bytes_reg, bytes_next;
    logic [7:0]                      shift_reg, shift_next;

    logic                            out_valid_reg, out_valid_next;
    logic [1:0]                      out_kind_reg;
    logic [7:0]                      out_byte_reg;
    logic [pwfr_pkg::BYTE_CNT_W-1:0] out_index_reg;

    logic                            res_valid;
    logic [1:0]                      res_kind;
    logic [7:0]                      res_byte;
    logic [pwfr_pkg::BYTE_CNT_W-1:0] res_index;
    logic [2:0]                      count_inc;
    logic [7:0]                      shift_bit;

    assign count_inc = count_reg + 3'd1;
    assign shift_bit = shift_reg | (8'(match.one_hit & ~match.zero_hit) << bitpos_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        bitpos_next = bitpos_reg;
        bytes_next  = bytes_reg;
        shift_next  = shift_reg;
        res_valid   = 1'b0;
        res_kind    = pwfr_pkg::KIND_REJECT;
        res_byte    = '0;
        res_index   = '0;
        if (rx_enable)
        begin
            if (phase_reg == PH_IDLE || phase_reg > PH_LEADOUT)
            begin
                if (!match.timeout)
                begin
                    phase_next  = PH_ZERO;
                    count_next  = '0;
                    bitpos_next = '0;
                    bytes_next  = '0;
                    shift_next  = '0;
                end
            end
            else
            begin
                logic hit;
                hit = 1'b0;
                unique case (phase_reg)
                    PH_ZERO:    hit = match.zero_hit;
                    PH_ONE:     hit = match.one_hit;
                    PH_DATA:    hit = match.zero_hit | match.one_hit;
                    default:    hit = match.trailer_hit;
                endcase
                if (match.timeout || !hit)
                begin
                    // drop the frame
                    res_valid   = 1'b1;
                    res_kind    = pwfr_pkg::KIND_REJECT;
                    phase_next  = PH_IDLE;
                    count_next  = '0;
                    bitpos_next = '0;
                    bytes_next  = '0;
                    shift_next  = '0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_ZERO, PH_ONE:
                        begin
                            count_next = count_inc;
                            if (count_inc >= pwfr_pkg::CAL_PULSES)
                            begin
                                phase_next = (phase_reg == PH_ZERO) ? PH_ONE : PH_TRAILER;
                                count_next = '0;
                            end
                        end
                        PH_TRAILER:
                        begin
                            phase_next  = PH_DATA;
                            bitpos_next = '0;
                            bytes_next  = '0;
                            shift_next  = '0;
                        end
                        PH_DATA:
                        begin
                            shift_next = shift_bit;
                            if (bitpos_reg == 3'd7)
                            begin
                                res_valid   = 1'b1;
                                res_kind    = pwfr_pkg::KIND_DATA;
                                res_byte    = shift_bit;
                                res_index   = bytes_reg;
                                bitpos_next = '0;
                                shift_next  = '0;
                                if (bytes_reg >= pwfr_pkg::LAST_BYTE)
                                begin
                                    phase_next = PH_LEADOUT;
                                    count_next = '0;
                                    bytes_next = '0;
                                end
                                else
                                begin
                                    bytes_next = bytes_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                bitpos_next = bitpos_reg + 3'd1;
                            end
                        end
                        default:
                        begin
                            count_next = count_inc;
                            if (count_inc >= pwfr_pkg::LEADOUT_PULSES)
                            begin
                                res_valid   = 1'b1;
                                res_kind    = pwfr_pkg::KIND_ACCEPT;
                                phase_next  = PH_IDLE;
                                count_next  = '0;
                                bitpos_next = '0;
                                bytes_next  = '0;
                                shift_next  = '0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // hold the item while its result cannot enter the result register
    assign item_taken = item_valid && (!res_valid || !out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (item_taken && res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            bitpos_reg    <= '0;
            bytes_reg     <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_taken)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                bitpos_reg <= bitpos_next;
                bytes_reg  <= bytes_next;
                shift_reg  <= shift_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_taken && res_valid)
        begin
            out_kind_reg  <= res_kind;
            out_byte_reg  <= res_byte;
            out_index_reg <= res_index;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_index = out_index_reg;

`ifndef SYNTH
    a_bitpos_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (bitpos_reg != '0) |-> (phase_reg == PH_DATA))
        else $error("bit position set outside data phase");

    a_bytes_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_reg != '0) |-> (phase_reg == PH_DATA))
        else $error("byte count set outside data phase");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (item_taken && res_valid) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != pwfr_pkg::KIND_DATA)
            |-> (out_byte_reg == '0 && out_index_reg == '0))
        else $error("status result carries data");
`endif

endmodule

// File: sv/pulse_width_frame_receiver.sv
// ---------------------------------------------------------------------------
// pulse_width_frame_receiver
// Decodes a framed stream of measured pulse widths into data bytes and a
// frame accepted or rejected status.
//
// Channel  Direction  Transfer content
// s_*      in         pulse width per transfer
// m_*      out        data byte and byte index, result kind on tuser
// cfg_*    in         register write, no read-back
//
// One pulse per cycle sustained while the output is not stalled; each pulse
// passes through the input register, then its result enters the result register.
// Reset clears the sequencer to idle and loads rx_enable 0, zero_width 4,
// one_width 8. A stalled output holds one result and one more pulse in the
// input register; pulses that give no result keep flowing meanwhile.
// ---------------------------------------------------------------------------
module pulse_width_frame_receiver (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [pwfr_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] pulse_width
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [7:0] data_byte, [13:8] byte_index
    output logic [1:0]                   m_tuser    // [1:0] kind
);

    logic                         rx_enable_reg;
    logic [pwfr_pkg::CFG_W-1:0]   zero_width_reg;
    logic [pwfr_pkg::CFG_W-1:0]   one_width_reg;

    logic                         in_valid_reg;
    logic [pwfr_pkg::WIDTH_W-1:0] in_width_reg;

    pwfr_pkg::match_t             match;
    logic                         item_taken;
    logic [7:0]                   out_byte;
    logic [pwfr_pkg::BYTE_CNT_W-1:0] out_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_enable_reg  <= 1'b0;
            zero_width_reg <= pwfr_pkg::CFG_W'(4);
            one_width_reg  <= pwfr_pkg::CFG_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwfr_pkg::REG_RX_ENABLE:  rx_enable_reg  <= cfg_wdata[0];
                pwfr_pkg::REG_ZERO_WIDTH: zero_width_reg <= cfg_wdata;
                pwfr_pkg::REG_ONE_WIDTH:  one_width_reg  <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    assign s_tready = !in_valid_reg || item_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_width_reg <= s_tdata;
        end
    end

    pwfr_match u_match (
        .pulse_width (in_width_reg),
        .zero_width  (zero_width_reg),
        .one_width   (one_width_reg),
        .match       (match)
    );

    pwfr_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_enable  (rx_enable_reg),
        .item_valid (in_valid_reg),
        .match      (match),
        .item_taken (item_taken),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_byte   (out_byte),
        .out_index  (out_index)
    );

    assign m_tdata = {2'b00, out_index, out_byte};

endmodule
